// ----- sv/pafr_pkg.sv -----
package pafr_pkg;

    localparam int NUM_ATOMS = 4096;
    localparam int ATOM_W = $clog2(NUM_ATOMS);
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ACCUM = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [1:0] RM_SUM = 2'd0;
    localparam logic [1:0] RM_MAX = 2'd1;
    localparam logic [1:0] RM_MIN = 2'd2;
    localparam logic [1:0] RM_AVG = 2'd3;

    localparam logic CFG_REDUCE = 1'b0;
    localparam logic CFG_SCALAR = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLR_WR,
        OP_MUL_VV,
        OP_ACC_SQ,
        OP_SQRT_V,
        OP_SAVE_NV,
        OP_SHR,
        OP_SHL,
        OP_MUL_RV,
        OP_ACC_DOT,
        OP_MUL_RR,
        OP_ACC_RR,
        OP_DOT_FIN,
        OP_SQRT_R,
        OP_DIV_DOT,
        OP_SET_S_NV,
        OP_SET_S_Q,
        OP_RD_A,
        OP_WR_A,
        OP_RD_B,
        OP_WR_B,
        OP_RD_CAP,
        OP_DIV_AVG,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_V_GO,
        S_SQRT_V_WAIT,
        S_SET_NV,
        S_SCALE,
        S_DOT_MUL,
        S_DOT_ACC,
        S_RR_MUL,
        S_RR_ACC,
        S_DOT_FIN,
        S_SQRT_R_GO,
        S_SQRT_R_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SET_Q,
        S_UPD_RD_A,
        S_UPD_WR_A,
        S_UPD_RD_B,
        S_UPD_WR_B,
        S_RD_MEM,
        S_RD_CAP,
        S_RD_CHK,
        S_AVG_GO,
        S_AVG_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       clr_last;
        logic       proj_mode;
        logic       avg_mode;
        logic       r_zero;
        logic       r_big;
        logic       r_norm;
        logic       sqrt_done;
        logic       root_zero;
        logic       div_done;
        logic       rc_zero;
        logic       out_full;
    } dp_status_t;

endpackage

// ----- sv/pafr_isqrt.sv -----
module pafr_isqrt
    import pafr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [63:0] trial;

    always_comb
    begin
        trial = res_reg + bit_reg;
        if (n_reg >= trial)
        begin
            n_next = n_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            n_next = n_reg;
            res_next = res_reg >> 1;
        end
        bit_next = bit_reg >> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= operand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            n_reg <= n_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ----- sv/pafr_div.sv -----
module pafr_div
    import pafr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg;
    logic [32:0] rem_sh, rem_sub;
    logic ge;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[63]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        ge = (rem_sh >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            dvd_reg <= {dvd_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- sv/pafr_datapath.sv -----
module pafr_datapath
    import pafr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_data,
    input  logic [1:0]         action,
    input  logic [11:0]        atom_first,
    input  logic [11:0]        atom_second,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] first_pos_z,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] second_pos_z,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [31:0]        atom_value,
    output logic [15:0]        interaction_count
);

    logic [1:0] reduce_mode_reg;
    logic       scalar_mode_reg;

    logic [1:0]  action_reg;
    logic [11:0] a_reg, b_reg;
    logic [31:0] vm_reg [3];
    logic        vn_reg [3];
    logic [32:0] rm_reg [3];
    logic        rn_reg [3];

    logic [63:0] prod_reg;
    logic [63:0] sq_reg, pos_reg, negs_reg, rr_reg;
    logic [31:0] nv_reg, s_reg;
    logic [31:0] rv_reg;
    logic [15:0] rc_reg;

    logic [ATOM_W-1:0] clr_addr_reg;

    logic [31:0] value_mem [NUM_ATOMS];
    logic [15:0] count_mem [NUM_ATOMS];
    logic [31:0] val_q;
    logic [15:0] cnt_q;

    logic        out_valid_reg;
    logic [31:0] atom_value_reg;
    logic [15:0] count_out_reg;

    logic signed [31:0] fv [3];
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
    logic signed [32:0] rdiff [3];

    logic [31:0] mul_a, mul_b;
    logic        sqrt_start, div_start, sqrt_done, div_done;
    logic [63:0] sqrt_op, div_dvd, quot;
    logic [31:0] div_dsr, root;

    logic        a_ok, b_ok, mem_rd, mem_we;
    logic [ATOM_W-1:0] rd_addr, wr_addr;
    logic [31:0] wr_val, upd_val;
    logic [15:0] wr_cnt, upd_cnt;
    logic [32:0] sum33;
    logic        any_big, any_norm, any_set;

    assign fv[0] = force_x;
    assign fv[1] = force_y;
    assign fv[2] = force_z;
    assign p1[0] = first_pos_x;
    assign p1[1] = first_pos_y;
    assign p1[2] = first_pos_z;
    assign p2[0] = second_pos_x;
    assign p2[1] = second_pos_y;
    assign p2[2] = second_pos_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rdiff[k] = {p2[k][31], p2[k]} - {p1[k][31], p1[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduce_mode_reg <= RM_SUM;
            scalar_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REDUCE: reduce_mode_reg <= cfg_data;
                CFG_SCALAR: scalar_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_MUL_VV:
            begin
                mul_a = vm_reg[cmd.k];
                mul_b = vm_reg[cmd.k];
            end
            OP_MUL_RV:
            begin
                mul_a = rm_reg[cmd.k][31:0];
                mul_b = vm_reg[cmd.k];
            end
            default:
            begin
                mul_a = rm_reg[cmd.k][31:0];
                mul_b = rm_reg[cmd.k][31:0];
            end
        endcase
    end

    always_comb
    begin
        any_big = 1'b0;
        any_norm = 1'b0;
        any_set = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            any_big = any_big | rm_reg[k][32] | rm_reg[k][31];
            any_norm = any_norm | rm_reg[k][30];
            any_set = any_set | (rm_reg[k] != '0);
        end
    end

    // item capture, products and accumulators
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                action_reg <= action;
                a_reg <= atom_first;
                b_reg <= atom_second;
                for (int k = 0; k < 3; k++)
                begin
                    vn_reg[k] <= fv[k][31];
                    vm_reg[k] <= fv[k][31] ? (32'd0 - 32'(fv[k])) : 32'(fv[k]);
                    rn_reg[k] <= rdiff[k][32];
                    rm_reg[k] <= rdiff[k][32] ? (33'd0 - 33'(rdiff[k])) : 33'(rdiff[k]);
                end
                sq_reg <= '0;
                pos_reg <= '0;
                negs_reg <= '0;
                rr_reg <= '0;
            end
            OP_MUL_VV, OP_MUL_RV, OP_MUL_RR:
                prod_reg <= 64'(mul_a) * 64'(mul_b);
            OP_ACC_SQ:
                sq_reg <= sq_reg + prod_reg;
            OP_ACC_DOT:
            begin
                if (rn_reg[cmd.k] != vn_reg[cmd.k])
                    negs_reg <= negs_reg + prod_reg;
                else
                    pos_reg <= pos_reg + prod_reg;
            end
            OP_ACC_RR:
                rr_reg <= rr_reg + prod_reg;
            OP_SAVE_NV:
                nv_reg <= root;
            OP_SHR:
                for (int k = 0; k < 3; k++)
                    rm_reg[k] <= rm_reg[k] >> 1;
            OP_SHL:
                for (int k = 0; k < 3; k++)
                    rm_reg[k] <= rm_reg[k] << 1;
            OP_DOT_FIN:
                pos_reg <= (pos_reg >= negs_reg) ? (pos_reg - negs_reg)
                                                 : (negs_reg - pos_reg);
            OP_SET_S_NV:
                s_reg <= nv_reg;
            OP_SET_S_Q:
                s_reg <= (quot > {32'd0, nv_reg}) ? nv_reg : quot[31:0];
            OP_RD_CAP:
            begin
                rv_reg <= a_ok ? val_q : '0;
                rc_reg <= a_ok ? cnt_q : '0;
            end
            default: ;
        endcase
    end

    assign sqrt_start = (cmd.op == OP_SQRT_V) || (cmd.op == OP_SQRT_R);
    assign sqrt_op = (cmd.op == OP_SQRT_R) ? rr_reg : sq_reg;
    assign div_start = (cmd.op == OP_DIV_DOT) || (cmd.op == OP_DIV_AVG);
    assign div_dvd = (cmd.op == OP_DIV_AVG) ? {32'd0, rv_reg} : pos_reg;
    assign div_dsr = (cmd.op == OP_DIV_AVG) ? {16'd0, rc_reg} : root;

    pafr_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_op),
        .done    (sqrt_done),
        .root    (root)
    );

    pafr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (quot)
    );

    // entry update
    assign a_ok = (32'(a_reg) < NUM_ATOMS);
    assign b_ok = (32'(b_reg) < NUM_ATOMS);

    always_comb
    begin
        sum33 = {1'b0, val_q} + {1'b0, s_reg};
        case (reduce_mode_reg)
            RM_MAX: upd_val = (s_reg > val_q) ? s_reg : val_q;
            RM_MIN: upd_val = ((val_q == '0) || (s_reg < val_q)) ? s_reg : val_q;
            default: upd_val = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
        endcase
        upd_cnt = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
    end

    assign mem_rd = (cmd.op == OP_RD_A) || (cmd.op == OP_RD_B);
    assign rd_addr = (cmd.op == OP_RD_B) ? ATOM_W'(b_reg) : ATOM_W'(a_reg);
    assign mem_we = (cmd.op == OP_CLR_WR) || ((cmd.op == OP_WR_A) && a_ok)
                    || ((cmd.op == OP_WR_B) && b_ok);

    always_comb
    begin
        case (cmd.op)
            OP_WR_A:
            begin
                wr_addr = ATOM_W'(a_reg);
                wr_val = upd_val;
                wr_cnt = upd_cnt;
            end
            OP_WR_B:
            begin
                wr_addr = ATOM_W'(b_reg);
                wr_val = upd_val;
                wr_cnt = upd_cnt;
            end
            default:
            begin
                wr_addr = clr_addr_reg;
                wr_val = '0;
                wr_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            val_q <= value_mem[rd_addr];
            cnt_q <= count_mem[rd_addr];
        end
        if (mem_we)
        begin
            value_mem[wr_addr] <= wr_val;
            count_mem[wr_addr] <= wr_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.op == OP_CLR_WR)
        begin
            if (clr_addr_reg == ATOM_W'(NUM_ATOMS - 1))
                clr_addr_reg <= '0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            if (reduce_mode_reg == RM_AVG)
                atom_value_reg <= (rc_reg == '0) ? '0 : quot[31:0];
            else
                atom_value_reg <= rv_reg;
            count_out_reg <= rc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign atom_value = atom_value_reg;
    assign interaction_count = count_out_reg;

    always_comb
    begin
        status.action = action_reg;
        status.clr_last = (clr_addr_reg == ATOM_W'(NUM_ATOMS - 1));
        status.proj_mode = scalar_mode_reg;
        status.avg_mode = (reduce_mode_reg == RM_AVG);
        status.r_zero = !any_set;
        status.r_big = any_big;
        status.r_norm = any_norm;
        status.sqrt_done = sqrt_done;
        status.root_zero = (root == '0);
        status.div_done = div_done;
        status.rc_zero = (rc_reg == '0);
        status.out_full = out_valid_reg;
    end

endmodule

// ----- sv/pafr_ctrl.sv -----
module pafr_ctrl
    import pafr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        cmd.op = OP_NOP;
        cmd.k = k_reg;
        in_stall = 1'b1;
        case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR_WR;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    k_next = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.action)
                    ACT_CLEAR: state_next = S_CLR;
                    ACT_ACCUM: state_next = S_SQ_MUL;
                    ACT_READ: state_next = S_RD_MEM;
                    default: state_next = S_IDLE;
                endcase
            end
            S_SQ_MUL:
            begin
                cmd.op = OP_MUL_VV;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op = OP_ACC_SQ;
                if (k_reg == 2'd2)
                begin
                    k_next = '0;
                    state_next = S_SQRT_V_GO;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQRT_V_GO:
            begin
                cmd.op = OP_SQRT_V;
                state_next = S_SQRT_V_WAIT;
            end
            S_SQRT_V_WAIT:
            begin
                if (status.sqrt_done)
                begin
                    cmd.op = OP_SAVE_NV;
                    if (!status.proj_mode || status.r_zero)
                        state_next = S_SET_NV;
                    else
                        state_next = S_SCALE;
                end
            end
            S_SET_NV:
            begin
                cmd.op = OP_SET_S_NV;
                state_next = S_UPD_RD_A;
            end
            S_SCALE:
            begin
                // one step right, or left steps until the top bit lands on bit 30
                if (status.r_big)
                begin
                    cmd.op = OP_SHR;
                    state_next = S_DOT_MUL;
                end
                else if (status.r_norm)
                    state_next = S_DOT_MUL;
                else
                    cmd.op = OP_SHL;
            end
            S_DOT_MUL:
            begin
                cmd.op = OP_MUL_RV;
                state_next = S_DOT_ACC;
            end
            S_DOT_ACC:
            begin
                cmd.op = OP_ACC_DOT;
                state_next = S_RR_MUL;
            end
            S_RR_MUL:
            begin
                cmd.op = OP_MUL_RR;
                state_next = S_RR_ACC;
            end
            S_RR_ACC:
            begin
                cmd.op = OP_ACC_RR;
                if (k_reg == 2'd2)
                begin
                    k_next = '0;
                    state_next = S_DOT_FIN;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                    state_next = S_DOT_MUL;
                end
            end
            S_DOT_FIN:
            begin
                cmd.op = OP_DOT_FIN;
                state_next = S_SQRT_R_GO;
            end
            S_SQRT_R_GO:
            begin
                cmd.op = OP_SQRT_R;
                state_next = S_SQRT_R_WAIT;
            end
            S_SQRT_R_WAIT:
            begin
                if (status.sqrt_done)
                    state_next = status.root_zero ? S_SET_NV : S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.op = OP_DIV_DOT;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = S_SET_Q;
            end
            S_SET_Q:
            begin
                cmd.op = OP_SET_S_Q;
                state_next = S_UPD_RD_A;
            end
            S_UPD_RD_A:
            begin
                cmd.op = OP_RD_A;
                state_next = S_UPD_WR_A;
            end
            S_UPD_WR_A:
            begin
                cmd.op = OP_WR_A;
                state_next = S_UPD_RD_B;
            end
            S_UPD_RD_B:
            begin
                cmd.op = OP_RD_B;
                state_next = S_UPD_WR_B;
            end
            S_UPD_WR_B:
            begin
                cmd.op = OP_WR_B;
                state_next = S_IDLE;
            end
            S_RD_MEM:
            begin
                cmd.op = OP_RD_A;
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                cmd.op = OP_RD_CAP;
                state_next = S_RD_CHK;
            end
            S_RD_CHK:
            begin
                if (status.avg_mode && !status.rc_zero)
                    state_next = S_AVG_GO;
                else
                    state_next = S_OUT;
            end
            S_AVG_GO:
            begin
                cmd.op = OP_DIV_AVG;
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the previous word has left
                if (!status.out_full)
                begin
                    cmd.op = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- sv/per_atom_force_reduce_top.sv -----
// Per-atom scalar force accumulator. Each word on the input channel is a clear,
// an accumulate or a read; the fourth action code is dropped. Only a read returns
// a word (value and count). The block takes one word at a time. An accumulate
// runs the 32-step square root unit in norm mode; in projection mode it can also
// run a second square root, up to 30 single-bit normalizing shifts and a 64-step
// divider. A read can run the shared divider in average mode. A clear, and the
// clearing pass after reset, writes one entry per cycle over all NUM_ATOMS (4096)
// entries; no input word is taken meanwhile, configuration writes are. A pending
// result word does not block the next input word.
module per_atom_force_reduce_top
    import pafr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [11:0]        atom_first,
    input  logic [11:0]        atom_second,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] first_pos_z,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] second_pos_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        atom_value,
    output logic [15:0]        interaction_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    pafr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pafr_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .action            (action),
        .atom_first        (atom_first),
        .atom_second       (atom_second),
        .force_x           (force_x),
        .force_y           (force_y),
        .force_z           (force_z),
        .first_pos_x       (first_pos_x),
        .first_pos_y       (first_pos_y),
        .first_pos_z       (first_pos_z),
        .second_pos_x      (second_pos_x),
        .second_pos_y      (second_pos_y),
        .second_pos_z      (second_pos_z),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .atom_value        (atom_value),
        .interaction_count (interaction_count)
    );

endmodule

// ----- sv/pafr_checker.sv -----
module pafr_checker
    import pafr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] atom_value,
    input logic [15:0] interaction_count,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // one word at a time: an accepted word closes the input
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous word still in work");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_CLEAR) |=> in_stall ##1 in_stall)
        else $error("clear sweep did not hold off input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(atom_value)
                                     && $stable(interaction_count))
        else $error("stalled result word changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind per_atom_force_reduce_top pafr_checker u_pafr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .atom_value        (atom_value),
    .interaction_count (interaction_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import pafr_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  act;
        logic [11:0] a;
        logic [11:0] b;
        logic [31:0] fx, fy, fz;
        logic [31:0] p1x, p1y, p1z;
        logic [31:0] p2x, p2y, p2z;
    } pair_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] count;
    } atom_read_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         action = '0;
    logic [11:0]        atom_first = '0;
    logic [11:0]        atom_second = '0;
    logic signed [31:0] force_x = '0, force_y = '0, force_z = '0;
    logic signed [31:0] first_pos_x = '0, first_pos_y = '0, first_pos_z = '0;
    logic signed [31:0] second_pos_x = '0, second_pos_y = '0, second_pos_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [31:0]        atom_value;
    logic [15:0]        interaction_count;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [1:0]         cfg_data = '0;

    per_atom_force_reduce_top dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] force_table [NUM_ATOMS];
    logic [15:0] hit_table [NUM_ATOMS];
    logic [1:0]  mode_reduce = RM_SUM;
    logic        mode_proj = 1'b0;

    pair_word_t  pending_words [$];
    atom_read_t  expected_reads [$];
    int          errors = 0;
    int          reads_seen = 0;
    int          words_sent = 0;
    longint      cycles = 0;
    bit          quiet_in = 1'b0;
    bit          quiet_out = 1'b0;

    function automatic logic [31:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] pair_scalar(pair_word_t w);
        logic signed [32:0] fv [3];
        logic signed [33:0] sep [3];
        logic [63:0] fm [3], rm [3];
        logic        fneg [3], rneg [3];
        logic [63:0] sq, big, pos, neg, dot, rr, q;
        logic [31:0] nv, nr;
        sq = 0; big = 0; pos = 0; neg = 0; rr = 0;
        fv[0] = $signed(w.fx); fv[1] = $signed(w.fy); fv[2] = $signed(w.fz);
        sep[0] = $signed(w.p2x) - $signed(w.p1x);
        sep[1] = $signed(w.p2y) - $signed(w.p1y);
        sep[2] = $signed(w.p2z) - $signed(w.p1z);
        for (int k = 0; k < 3; k++)
        begin
            fneg[k] = fv[k] < 0;
            fm[k] = fneg[k] ? 64'(-fv[k]) : 64'(fv[k]);
            sq += fm[k] * fm[k];
            rneg[k] = sep[k] < 0;
            rm[k] = rneg[k] ? 64'(-sep[k]) : 64'(sep[k]);
            if (rm[k] > big) big = rm[k];
        end
        nv = int_sqrt(sq);
        if (!mode_proj || big == 0) return nv;
        if (big >= 64'd1 << 31)
            for (int k = 0; k < 3; k++) rm[k] >>= 1;
        else
            while (big < 64'd1 << 30)
            begin
                big <<= 1;
                for (int k = 0; k < 3; k++) rm[k] <<= 1;
            end
        for (int k = 0; k < 3; k++)
        begin
            if (rneg[k] != fneg[k]) neg += rm[k] * fm[k];
            else pos += rm[k] * fm[k];
            rr += rm[k] * rm[k];
        end
        dot = pos >= neg ? pos - neg : neg - pos;
        nr = int_sqrt(rr);
        if (nr == 0) return nv;
        q = dot / nr;
        if (q > nv) q = nv;
        return q[31:0];
    endfunction

    function automatic void update_entry(logic [11:0] idx, logic [31:0] s);
        logic [31:0] cur;
        cur = force_table[idx];
        case (mode_reduce)
            RM_MAX: if (s > cur) force_table[idx] = s;
            RM_MIN: if (cur == 0 || s < cur) force_table[idx] = s;
            default: force_table[idx] = (cur > 32'hFFFF_FFFF - s) ? 32'hFFFF_FFFF : cur + s;
        endcase
        if (hit_table[idx] != 16'hFFFF) hit_table[idx]++;
    endfunction

    function automatic void predict_word(pair_word_t w);
        logic [31:0] s, v;
        logic [15:0] c;
        case (w.act)
            ACT_CLEAR:
                for (int i = 0; i < NUM_ATOMS; i++)
                begin
                    force_table[i] = 0;
                    hit_table[i] = 0;
                end
            ACT_ACCUM:
            begin
                s = pair_scalar(w);
                update_entry(w.a, s);
                update_entry(w.b, s);
            end
            ACT_READ:
            begin
                v = force_table[w.a];
                c = hit_table[w.a];
                if (mode_reduce == RM_AVG) v = (c == 0) ? 0 : v / c;
                expected_reads.push_back('{value: v, count: c});
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (read %0d)", what, got, want, reads_seen);
        errors++;
    endtask

    // stall as seen at the last rising edge: decides whether the held word went in
    logic in_stall_q = 1'b1;
    always @(posedge clk)
    begin
        in_stall_q <= in_stall;
    end

    // driver
    always @(negedge clk)
    begin
        pair_word_t w;
        logic       send;
        send = rst_n && (!in_valid || !in_stall_q) && pending_words.size() > 0
               && (quiet_in || $urandom_range(99) >= 22);
        if (send)
        begin
            w = pending_words.pop_front();
            predict_word(w);
            words_sent++;
            in_valid <= 1'b1;
            action <= w.act; atom_first <= w.a; atom_second <= w.b;
            force_x <= w.fx; force_y <= w.fy; force_z <= w.fz;
            first_pos_x <= w.p1x; first_pos_y <= w.p1y; first_pos_z <= w.p1z;
            second_pos_x <= w.p2x; second_pos_y <= w.p2y; second_pos_z <= w.p2z;
        end
        else if (rst_n && in_valid && !in_stall_q)
            in_valid <= 1'b0;
        out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 22);
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            atom_read_t e;
            reads_seen++;
            if (expected_reads.size() == 0)
            begin
                report("unexpected read", atom_value, 32'd0);
            end
            else
            begin
                e = expected_reads.pop_front();
                if (atom_value !== e.value) report("atom_value", atom_value, e.value);
                if (interaction_count !== e.count)
                    report("interaction_count", 32'(interaction_count), 32'(e.count));
            end
        end
        if (cycles > 3_000_000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(8'hFF) - 128;
            3: return 32'(int'($urandom_range(20'hFFFFF)) - 20'h80000) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic pair_word_t make_word(logic [1:0] act, logic [11:0] a,
                                             logic [11:0] b);
        pair_word_t w;
        w.act = act; w.a = a; w.b = b;
        w.fx = rand_word(); w.fy = rand_word(); w.fz = rand_word();
        w.p1x = rand_word(); w.p1y = rand_word(); w.p1z = rand_word();
        w.p2x = rand_word(); w.p2y = rand_word(); w.p2z = rand_word();
        return w;
    endfunction

    task automatic write_reg(logic idx, logic [1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_REDUCE) mode_reduce = data;
        else mode_proj = data[0];
    endtask

    // wait for the queue to drain and the block to settle (a clear sweeps all NUM_ATOMS entries)
    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_reads.size() > 0)
            @(posedge clk);
        repeat (NUM_ATOMS + 400) @(posedge clk);
    endtask

    initial
    begin
        pair_word_t w;
        logic [11:0] hot [8];
        for (int i = 0; i < NUM_ATOMS; i++)
        begin
            force_table[i] = 0;
            hit_table[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, same atom twice, zero separation, unused action
        w = make_word(ACT_ACCUM, 12'd0, 12'd4095);
        w.fx = 32'h8000_0000; w.fy = 32'h8000_0000; w.fz = 32'h8000_0000;
        pending_words.push_back(w);
        w = make_word(ACT_ACCUM, 12'd5, 12'd5);
        w.fx = 32'h7FFF_FFFF; w.fy = 0; w.fz = 0;
        w.p2x = w.p1x; w.p2y = w.p1y; w.p2z = w.p1z;
        pending_words.push_back(w);
        w = make_word(ACT_ACCUM, 12'd7, 12'd8);
        w.fx = 0; w.fy = 0; w.fz = 0;
        pending_words.push_back(w);
        pending_words.push_back(make_word(ACT_UNUSED, 12'd0, 12'd0));
        foreach (hot[i]) hot[i] = (i < 4) ? 12'(i * 1365) : 12'(i);
        pending_words.push_back(make_word(ACT_READ, 12'd0, 12'd0));
        pending_words.push_back(make_word(ACT_READ, 12'd4095, 12'd0));
        pending_words.push_back(make_word(ACT_READ, 12'd5, 12'd0));
        pending_words.push_back(make_word(ACT_READ, 12'd7, 12'd0));
        pending_words.push_back(make_word(ACT_READ, 12'd100, 12'd0));
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(CFG_REDUCE, 2'(phase));
            write_reg(CFG_SCALAR, phase[2]);
            quiet_in = (phase == 3);
            quiet_out = (phase == 3);
            pending_words.push_back(make_word(ACT_CLEAR, 12'd0, 12'd0));
            for (int n = 0; n < 40; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4:
                        pending_words.push_back(make_word(ACT_ACCUM,
                            hot[3'($urandom_range(7))], hot[3'($urandom_range(7))]));
                    5: pending_words.push_back(make_word(ACT_ACCUM,
                            12'($urandom), 12'($urandom)));
                    6, 7: pending_words.push_back(make_word(ACT_READ,
                            hot[3'($urandom_range(7))], 12'($urandom)));
                    8: pending_words.push_back(make_word(ACT_READ,
                            12'($urandom), 12'($urandom)));
                    default: pending_words.push_back(make_word(ACT_UNUSED,
                            12'($urandom), 12'($urandom)));
                endcase
            end
            foreach (hot[i]) pending_words.push_back(make_word(ACT_READ, hot[i], 12'd0));
            drain();
        end

        $display("sent %0d words, checked %0d reads over all reduce and scalar modes",
                 words_sent, reads_seen);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
